@@ sv/compact_extent_table_unit_defines.svh @@
// assertion macros for the extent table datapath
`ifndef COMPACT_EXTENT_TABLE_UNIT_DEFINES_SVH
`define COMPACT_EXTENT_TABLE_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CET_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CET_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CET_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/cet_pkg.sv @@
`default_nettype none

package cet_pkg;

   // fixed field widths
   localparam int SLOT_BITS        = 4;
   localparam int FIELD_W          = 16;
   localparam int TOTAL_W          = 20;
   localparam int USED_OUT_W       = 5;
   localparam int STATUS_W         = 2;

   // table size default and chunk index width
   localparam int EXTENT_SLOTS_DEF = 16;
   localparam int CHUNK_INDEX_BITS = 16;

   // mask applied to a granted start index
   localparam int START_KEEP = (CHUNK_INDEX_BITS < FIELD_W) ? CHUNK_INDEX_BITS : FIELD_W;
   localparam logic [FIELD_W-1:0] START_MASK =
      FIELD_W'((33'(1) << START_KEEP) - 33'(1));

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_ALLOC_FAIL = 2'd2,
      STATUS_BAD_SLOT   = 2'd3
   } cet_status_type;

   // controller to datapath commands
   typedef struct packed {
      logic           capture;
      logic           alloc_write;
      logic           reject;
      cet_status_type reject_code;
      logic           free_start;
      logic           rd_en;
      logic           rd_next;
      logic           free_take;
      logic           shift_write;
      logic           emit;
   } cet_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_free;
      logic table_full;
      logic grant_ok;
      logic slot_bad;
      logic shift_more;
      logic out_free;
   } cet_stat_type;

endpackage

`default_nettype wire

@@ sv/cet_req_if.sv @@
`default_nettype none

interface cet_req_if import cet_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [SLOT_BITS-1:0] slot;
   logic [FIELD_W-1:0]   chunk_count;
   logic [FIELD_W-1:0]   grant_start;
   logic                 grant_ok;

   modport source (output valid, req_type, slot, chunk_count, grant_start, grant_ok,
                   input ready);
   modport sink   (input valid, req_type, slot, chunk_count, grant_start, grant_ok,
                   output ready);
endinterface

`default_nettype wire

@@ sv/cet_rsp_if.sv @@
`default_nettype none

interface cet_rsp_if import cet_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_BITS-1:0]  slot_used;
   logic [FIELD_W-1:0]    freed_start;
   logic [FIELD_W-1:0]    freed_count;
   logic [TOTAL_W-1:0]    allocated_total;
   logic [USED_OUT_W-1:0] extents_in_use;

   modport source (output valid, status, slot_used, freed_start, freed_count,
                   allocated_total, extents_in_use, input ready);
   modport sink   (input valid, status, slot_used, freed_start, freed_count,
                   allocated_total, extents_in_use, output ready);
endinterface

`default_nettype wire

@@ sv/cet_ram.sv @@
`default_nettype none

module cet_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/cet_ctrl.sv @@
`default_nettype none

module cet_ctrl import cet_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire cet_stat_type stat,
   output cet_cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_FREE_RD,
      S_FREE_DATA,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.reject_code = STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            priority if (!stat.is_free && stat.table_full) begin
               cmd.reject      = 1'b1;
               cmd.reject_code = STATUS_FULL;
               state_in        = S_EMIT;
            end else if (!stat.is_free && !stat.grant_ok) begin
               cmd.reject      = 1'b1;
               cmd.reject_code = STATUS_ALLOC_FAIL;
               state_in        = S_EMIT;
            end else if (!stat.is_free) begin
               cmd.alloc_write = 1'b1;
               state_in        = S_EMIT;
            end else if (stat.slot_bad) begin
               cmd.reject      = 1'b1;
               cmd.reject_code = STATUS_BAD_SLOT;
               state_in        = S_EMIT;
            end else begin
               cmd.free_start = 1'b1;
               state_in       = S_FREE_RD;
            end
         end
         S_FREE_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_FREE_DATA;
         end
         S_FREE_DATA: begin
            cmd.free_take = 1'b1;
            state_in      = S_SHIFT_RD;
         end
         S_SHIFT_RD: begin
            if (stat.shift_more) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = S_SHIFT_WR;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_write = 1'b1;
            state_in        = S_SHIFT_RD;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/cet_datapath.sv @@
`default_nettype none

`include "compact_extent_table_unit_defines.svh"

module cet_datapath import cet_pkg::*; #(
   parameter int EXTENT_SLOTS = EXTENT_SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cet_cmd_type           cmd,
   output cet_stat_type               stat,
   // request word
   input  wire logic                  req_type,
   input  wire logic [SLOT_BITS-1:0]  req_slot,
   input  wire logic [FIELD_W-1:0]    req_chunk_count,
   input  wire logic [FIELD_W-1:0]    req_grant_start,
   input  wire logic                  req_grant_ok,
   // response word
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_BITS-1:0]       rsp_slot_used,
   output logic [FIELD_W-1:0]         rsp_freed_start,
   output logic [FIELD_W-1:0]         rsp_freed_count,
   output logic [TOTAL_W-1:0]         rsp_allocated_total,
   output logic [USED_OUT_W-1:0]      rsp_extents_in_use
);

   localparam int IdxW  = $clog2(EXTENT_SLOTS);
   localparam int CntW  = $clog2(EXTENT_SLOTS + 1);
   localparam int CmpW  = (CntW > SLOT_BITS) ? CntW : SLOT_BITS;
   localparam int DataW = 2 * FIELD_W;

   // captured request
   logic                 type_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [FIELD_W-1:0]   count_ff;
   logic [FIELD_W-1:0]   start_ff;
   logic                 ok_ff;

   // table bookkeeping
   logic [CntW-1:0]    used_ff, used_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [IdxW-1:0]    pos_ff, pos_in;

   // held result
   cet_status_type       res_status_ff, res_status_in;
   logic [SLOT_BITS-1:0] res_slot_ff, res_slot_in;
   logic [FIELD_W-1:0]   res_start_ff, res_start_in;
   logic [FIELD_W-1:0]   res_count_ff, res_count_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [SLOT_BITS-1:0]  out_slot_ff;
   logic [FIELD_W-1:0]    out_start_ff;
   logic [FIELD_W-1:0]    out_count_ff;
   logic [TOTAL_W-1:0]    out_total_ff;
   logic [USED_OUT_W-1:0] out_used_ff;

   // extent store
   logic             wr_en;
   logic [IdxW-1:0]  wr_addr;
   logic [DataW-1:0] wr_data;
   logic [IdxW-1:0]  rd_addr;
   logic [DataW-1:0] rd_data;
   logic             out_free;

   cet_ram #(
      .WIDTH (DataW),
      .DEPTH (EXTENT_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // store ports: allocate appends at the fill count, shifting moves one slot left
   assign wr_en   = cmd.alloc_write || cmd.shift_write;
   assign wr_addr = cmd.alloc_write ? used_ff[IdxW-1:0] : pos_ff;
   assign wr_data = cmd.alloc_write ? {start_ff & START_MASK, count_ff} : rd_data;
   assign rd_addr = cmd.rd_next ? (pos_ff + IdxW'(1)) : pos_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // status towards the controller; occupied slots always form a prefix
   always_comb begin
      stat            = '0;
      stat.is_free    = (type_ff == REQ_FREE);
      stat.table_full = (used_ff == CntW'(EXTENT_SLOTS));
      stat.grant_ok   = ok_ff;
      stat.slot_bad   = (CmpW'(slot_ff) >= CmpW'(used_ff));
      stat.shift_more = (CntW'(pos_ff) < used_ff);
      stat.out_free   = out_free;
   end

   // next values of bookkeeping and held result
   always_comb begin
      used_in       = used_ff;
      total_in      = total_ff;
      pos_in        = pos_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_start_in  = res_start_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (cmd.alloc_write) begin
         used_in       = used_ff + CntW'(1);
         total_in      = total_ff + TOTAL_W'(count_ff);
         res_status_in = STATUS_OK;
         res_slot_in   = SLOT_BITS'(used_ff);
         res_start_in  = '0;
         res_count_in  = '0;
      end
      if (cmd.reject) begin
         res_status_in = cmd.reject_code;
         res_slot_in   = '0;
         res_start_in  = '0;
         res_count_in  = '0;
      end
      if (cmd.free_start) begin
         pos_in = IdxW'(slot_ff);
      end
      if (cmd.free_take) begin
         used_in       = used_ff - CntW'(1);
         total_in      = total_ff - TOTAL_W'(rd_data[FIELD_W-1:0]);
         res_status_in = STATUS_OK;
         res_slot_in   = '0;
         res_start_in  = rd_data[DataW-1:FIELD_W];
         res_count_in  = rd_data[FIELD_W-1:0];
      end
      if (cmd.shift_write) begin
         pos_in = pos_ff + IdxW'(1);
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         slot_ff  <= req_slot;
         count_ff <= req_chunk_count;
         start_ff <= req_grant_start;
         ok_ff    <= req_grant_ok;
      end
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_start_ff  <= res_start_in;
      res_count_ff  <= res_count_in;
      if (cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= res_slot_ff;
         out_start_ff  <= res_start_ff;
         out_count_ff  <= res_count_ff;
         out_total_ff  <= total_ff;
         out_used_ff   <= USED_OUT_W'(used_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_slot_used       = out_slot_ff;
   assign rsp_freed_start     = out_start_ff;
   assign rsp_freed_count     = out_count_ff;
   assign rsp_allocated_total = out_total_ff;
   assign rsp_extents_in_use  = out_used_ff;

   // checks
   `CET_ASSERT_ALWAYS(a_used_bound, used_ff <= CntW'(EXTENT_SLOTS), "fill count beyond table")
   `CET_ASSERT_NEXT(a_alloc_grows, cmd.alloc_write, used_ff == $past(used_ff) + CntW'(1), "no growth")
   `CET_ASSERT_IMPLIES(a_shift_in_prefix, cmd.shift_write, CntW'(pos_ff) < used_ff, "shift past end")
   `CET_ASSERT_IMPLIES(a_emit_free, cmd.emit, out_free, "result overwrites a pending response")

endmodule

`default_nettype wire

@@ sv/compact_extent_table_unit.sv @@
// compact extent table
// req_bus takes one request word (allocate or free) when valid and ready are
// both high; rsp_bus returns exactly one response word per request, in order.
// ready on req_bus is high only while no request is being worked on; a new
// request may be taken while the previous response still waits on rsp_bus.
// a request is captured and then decided in turn. an allocate or a
// rejected request then goes straight to the response register; a
// successful free first reads the freed entry, then moves each later entry
// one slot left through the single read and single write port of the
// extent store, a read and then a write per entry, before its response is
// raised. the controller returns to idle as the response is raised and
// takes the next request from there.
// occupied slots always form a prefix, so the fill count alone tells which
// slots hold an extent and the store needs no clearing after reset.
// reset empties the table, zeroes the running total and drops any response.
// a stalled receiver holds the response word steady; the block finishes the
// next request and then waits with it until the response register frees.
`default_nettype none

module compact_extent_table_unit import cet_pkg::*; #(
   parameter int EXTENT_SLOTS = EXTENT_SLOTS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   cet_req_if.sink   req_bus,
   cet_rsp_if.source rsp_bus
);

   cet_cmd_type  cmd;
   cet_stat_type stat;
   logic         req_ready;

   // sequencer
   cet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   // table, totals and response register
   cet_datapath #(
      .EXTENT_SLOTS (EXTENT_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_bus.req_type),
      .req_slot            (req_bus.slot),
      .req_chunk_count     (req_bus.chunk_count),
      .req_grant_start     (req_bus.grant_start),
      .req_grant_ok        (req_bus.grant_ok),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_status          (rsp_bus.status),
      .rsp_slot_used       (rsp_bus.slot_used),
      .rsp_freed_start     (rsp_bus.freed_start),
      .rsp_freed_count     (rsp_bus.freed_count),
      .rsp_allocated_total (rsp_bus.allocated_total),
      .rsp_extents_in_use  (rsp_bus.extents_in_use)
   );

endmodule

`default_nettype wire
